>>> rtl/tea_pkg.sv
package tea_pkg;

  // Round constant added to the running total every round
  localparam logic [31:0] GOLDEN = 32'h9E37_79B9;

  // Configuration register indexes
  localparam logic [2:0] REG_KEY0 = 3'd0;
  localparam logic [2:0] REG_KEY1 = 3'd1;
  localparam logic [2:0] REG_KEY2 = 3'd2;
  localparam logic [2:0] REG_KEY3 = 3'd3;
  localparam logic [2:0] REG_MODE = 3'd4;

  // Mode codes
  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  // Key values after reset
  localparam logic [31:0] KEY0_RESET = 32'h95A8_882C;
  localparam logic [31:0] KEY1_RESET = 32'h9D2C_C113;
  localparam logic [31:0] KEY2_RESET = 32'h815A_A0CD;
  localparam logic [31:0] KEY3_RESET = 32'hA1C4_89F7;

  typedef logic [31:0] tea_word_t;

  // Key set and mode as seen by every round stage
  typedef struct packed {
    tea_word_t key0;
    tea_word_t key1;
    tea_word_t key2;
    tea_word_t key3;
    logic      decrypt;
  } tea_cfg_t;

  // One block in flight, with the mode it was accepted under
  typedef struct packed {
    tea_word_t high;
    tea_word_t low;
    logic      decrypt;
  } tea_beat_t;

endpackage

>>> rtl/tea_cfg_regs.sv
module tea_cfg_regs (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data,
  output tea_pkg::tea_cfg_t cfg
);
  import tea_pkg::*;

  tea_cfg_t regs;

  // Load reset key and mode, then take writes by index; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.key0    <= KEY0_RESET;
      regs.key1    <= KEY1_RESET;
      regs.key2    <= KEY2_RESET;
      regs.key3    <= KEY3_RESET;
      regs.decrypt <= MODE_ENCRYPT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY0: regs.key0    <= cfg_data;
        REG_KEY1: regs.key1    <= cfg_data;
        REG_KEY2: regs.key2    <= cfg_data;
        REG_KEY3: regs.key3    <= cfg_data;
        REG_MODE: regs.decrypt <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

>>> rtl/tea_round_stage.sv
module tea_round_stage #(
  parameter int ROUND_COUNT = 32,
  parameter int ROUND       = 0,
  parameter bit SECOND      = 1'b0
) (
  input  logic               clk,
  input  logic               rst,
  input  tea_pkg::tea_cfg_t  cfg,
  input  logic               in_valid,
  input  tea_pkg::tea_beat_t in_beat,
  output logic               out_valid,
  output tea_pkg::tea_beat_t out_beat
);
  import tea_pkg::*;

  // Running totals for this round, fixed at elaboration
  localparam logic [63:0] ENC_PROD = 64'(GOLDEN) * 64'(ROUND + 1);
  localparam logic [63:0] DEC_PROD = 64'(GOLDEN) * 64'(ROUND_COUNT - ROUND);
  localparam tea_word_t   ENC_SUM  = ENC_PROD[31:0];
  localparam tea_word_t   DEC_SUM  = DEC_PROD[31:0];

  logic      update_high;
  tea_word_t src;
  tea_word_t dst;
  tea_word_t ka;
  tea_word_t kb;
  tea_word_t total;
  tea_word_t mix;
  tea_word_t dst_next;
  tea_beat_t beat_next;
  logic      valid;
  tea_beat_t beat;

  // Pick which half moves: encrypt moves high first, decrypt moves low first
  always_comb begin
    update_high = SECOND ? (in_beat.decrypt == MODE_DECRYPT)
                         : (in_beat.decrypt == MODE_ENCRYPT);
    src   = update_high ? in_beat.low  : in_beat.high;
    dst   = update_high ? in_beat.high : in_beat.low;
    ka    = update_high ? cfg.key0 : cfg.key2;
    kb    = update_high ? cfg.key1 : cfg.key3;
    total = (in_beat.decrypt == MODE_DECRYPT) ? DEC_SUM : ENC_SUM;
    mix   = ((src << 4) + ka) ^ (src + total) ^ ((src >> 5) + kb);
    dst_next = (in_beat.decrypt == MODE_DECRYPT) ? dst - mix : dst + mix;

    beat_next = in_beat;
    if (update_high) begin
      beat_next.high = dst_next;
    end else begin
      beat_next.low = dst_next;
    end
  end

  // Advance valid under reset, data without
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    beat <= beat_next;
  end

  assign out_valid = valid;
  assign out_beat  = beat;

endmodule

>>> rtl/tea_block_cipher_top.sv
// TEA block cipher, one half-round per pipeline stage, 2*ROUND_COUNT stages.
// Done is the valid bit registered out of the last stage, so it pulses once
// a block has passed through the whole stage chain.
// Throughput: one block per cycle; busy stays low and a block may start
// every cycle. The receiver cannot stall, so no beat is held back.
// Reset clears all stage valid bits and restores the default key and mode.
module tea_block_cipher_top #(
  parameter int ROUND_COUNT = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] block_high,
  input  logic [31:0] block_low,
  output logic        done,
  output logic [31:0] out_high,
  output logic [31:0] out_low,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import tea_pkg::*;

  localparam int STAGES = 2 * ROUND_COUNT;

  tea_cfg_t  cfg;
  logic      stage_valid [STAGES+1];
  tea_beat_t stage_beat  [STAGES+1];

  tea_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Feed the first stage straight from the ports, with the configured mode
  assign busy                   = 1'b0;
  assign stage_valid[0]         = start;
  assign stage_beat[0].high     = block_high;
  assign stage_beat[0].low      = block_low;
  assign stage_beat[0].decrypt  = cfg.decrypt;

  // Chain the half-round stages
  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    tea_round_stage #(
      .ROUND_COUNT (ROUND_COUNT),
      .ROUND       (s / 2),
      .SECOND      ((s % 2) == 1)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .cfg       (cfg),
      .in_valid  (stage_valid[s]),
      .in_beat   (stage_beat[s]),
      .out_valid (stage_valid[s+1]),
      .out_beat  (stage_beat[s+1])
    );
  end

  // Present the last stage as the result beat
  assign done     = stage_valid[STAGES];
  assign out_high = stage_beat[STAGES].high;
  assign out_low  = stage_beat[STAGES].low;

endmodule
